// ===== hdl/assert_macros.svh =====
// Assertion macros for the joystick map RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication or invariant, disabled while reset is asserted.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Antecedent this cycle, consequent on the next clock edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/jacm_pkg.sv =====
// Shared types, constants and helper functions for the joystick calibrated map.
`default_nettype none

package jacm_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int RAW_W       = 8;
    localparam int WIDE_W      = 13;
    localparam int NARROW_W    = 8;
    localparam int CFG_IDX_W   = 4;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_X_NEG_LOW  = 4'd0,
        REG_X_NEG_HIGH = 4'd1,
        REG_X_POS_LOW  = 4'd2,
        REG_X_POS_HIGH = 4'd3,
        REG_Y_NEG_LOW  = 4'd4,
        REG_Y_NEG_HIGH = 4'd5,
        REG_Y_POS_LOW  = 4'd6,
        REG_Y_POS_HIGH = 4'd7
    } t_cal_reg;

    localparam logic [SAMPLE_W-1:0] NEG_LOW_RST  = 16'd0;
    localparam logic [SAMPLE_W-1:0] NEG_HIGH_RST = 16'd31743;
    localparam logic [SAMPLE_W-1:0] POS_LOW_RST  = 16'd33791;
    localparam logic [SAMPLE_W-1:0] POS_HIGH_RST = 16'd65535;

    typedef struct packed {
        logic [SAMPLE_W-1:0] neg_low;
        logic [SAMPLE_W-1:0] neg_high;
        logic [SAMPLE_W-1:0] pos_low;
        logic [SAMPLE_W-1:0] pos_high;
    } t_axis_cal;

    typedef struct packed {
        logic zero;
        logic neg;
    } t_div_ctl;

    typedef struct packed {
        logic [RAW_W-1:0]           raw;
        logic signed [WIDE_W-1:0]   wide;
        logic signed [NARROW_W-1:0] narrow;
    } t_lane_res;

    function automatic int q_width(input int fs);
        return $clog2(fs + 1);
    endfunction

    function automatic int div_stages(input int wide_fs, input int narrow_fs);
        return (q_width(wide_fs) > q_width(narrow_fs)) ? q_width(wide_fs) : q_width(narrow_fs);
    endfunction

    function automatic int lane_latency(input int wide_fs, input int narrow_fs);
        return 5 + div_stages(wide_fs, narrow_fs);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/jacm_div.sv =====
// Pipelined restoring divider that maps one axis span onto a clamped output range.
`default_nettype none

module jacm_div #(
    parameter int FS     = 4095,
    parameter int STAGES = 12,
    parameter int OW     = 13
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic [15:0]               i_dmag,
    input  wire logic [15:0]               i_smag,
    input  wire jacm_pkg::t_div_ctl        i_ctl,
    output logic signed [OW-1:0]           o_res
);

    localparam int QW    = jacm_pkg::q_width(FS);
    localparam int NUM_W = 16 + QW;
    localparam int RES_W = (QW + 1 > OW) ? QW + 1 : OW;

    logic [NUM_W-1:0]          r_num;
    logic [15:0]               r_den_m;
    logic                      r_sat_m;
    jacm_pkg::t_div_ctl        r_ctl_m;

    logic [15:0]               r_rem [STAGES];
    logic [QW-1:0]             r_low [STAGES];
    logic [QW-1:0]             r_quo [STAGES];
    logic [15:0]               r_den [STAGES];
    logic                      r_sat [STAGES];
    jacm_pkg::t_div_ctl        r_ctl [STAGES];

    logic signed [RES_W-1:0]   r_res;
    logic signed [RES_W-1:0]   n_qc;
    logic signed [RES_W-1:0]   n_res;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num   <= NUM_W'(i_dmag) * NUM_W'(FS);
            r_den_m <= i_smag;
            r_sat_m <= (i_dmag >= i_smag);
            r_ctl_m <= i_ctl;
        end
    end

    for (genvar k = 0; k < STAGES; k++) begin : g_stage
        logic [15:0]        w_rem_p;
        logic [QW-1:0]      w_low_p;
        logic [QW-1:0]      w_quo_p;
        logic [15:0]        w_den_p;
        logic               w_sat_p;
        jacm_pkg::t_div_ctl w_ctl_p;

        if (k == 0) begin : g_first
            assign w_rem_p = r_num[NUM_W-1:QW];
            assign w_low_p = r_num[QW-1:0];
            assign w_quo_p = '0;
            assign w_den_p = r_den_m;
            assign w_sat_p = r_sat_m;
            assign w_ctl_p = r_ctl_m;
        end else begin : g_next
            assign w_rem_p = r_rem[k-1];
            assign w_low_p = r_low[k-1];
            assign w_quo_p = r_quo[k-1];
            assign w_den_p = r_den[k-1];
            assign w_sat_p = r_sat[k-1];
            assign w_ctl_p = r_ctl[k-1];
        end

        if (k < QW) begin : g_step
            logic [16:0] w_trial;
            logic [16:0] w_diff;
            logic        w_ge;
            logic [QW:0] w_quo_n;

            assign w_trial = {w_rem_p, w_low_p[QW-1]};
            assign w_diff  = w_trial - {1'b0, w_den_p};
            assign w_ge    = (w_trial >= {1'b0, w_den_p});
            assign w_quo_n = {w_quo_p, w_ge};

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_ge ? w_diff[15:0] : w_trial[15:0];
                    r_low[k] <= w_low_p << 1;
                    r_quo[k] <= w_quo_n[QW-1:0];
                    r_den[k] <= w_den_p;
                    r_sat[k] <= w_sat_p;
                    r_ctl[k] <= w_ctl_p;
                end
            end
        end else begin : g_hold
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= w_rem_p;
                    r_low[k] <= w_low_p;
                    r_quo[k] <= w_quo_p;
                    r_den[k] <= w_den_p;
                    r_sat[k] <= w_sat_p;
                    r_ctl[k] <= w_ctl_p;
                end
            end
        end
    end

    always_comb begin
        if (r_ctl[STAGES-1].zero) begin
            n_qc = '0;
        end else if (r_sat[STAGES-1]) begin
            n_qc = RES_W'(FS);
        end else begin
            n_qc = signed'({{(RES_W-QW){1'b0}}, r_quo[STAGES-1]});
        end
        n_res = r_ctl[STAGES-1].neg ? (n_qc - RES_W'(FS)) : n_qc;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res[OW-1:0];

endmodule

`default_nettype wire

// ===== hdl/jacm_lane.sv =====
// One axis lane: zone select, span setup, raw byte and the two range dividers.
`default_nettype none

module jacm_lane #(
    parameter int WIDE_FS   = 4095,
    parameter int NARROW_FS = 127
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [15:0]           i_sample,
    input  wire jacm_pkg::t_axis_cal   i_cal,
    output jacm_pkg::t_lane_res        o_res
);

    localparam int STAGES = jacm_pkg::div_stages(WIDE_FS, NARROW_FS);
    localparam int LAT    = jacm_pkg::lane_latency(WIDE_FS, NARROW_FS);

    logic [15:0]        r1_s;
    logic [15:0]        r1_lo;
    logic [15:0]        r1_hi;
    logic               r1_neg;
    logic               r1_pos;

    logic [16:0]        r2_d;
    logic [16:0]        r2_span;
    logic               r2_neg;
    logic               r2_dead;

    logic [15:0]        r3_dmag;
    logic [15:0]        r3_smag;
    jacm_pkg::t_div_ctl r3_ctl;

    logic [jacm_pkg::RAW_W-1:0] r_raw [LAT];

    logic               n_neg;
    logic [15:0]        n_raw_t;
    logic [16:0]        n_dneg;
    logic [16:0]        n_sneg;

    assign n_neg   = (i_sample <= i_cal.neg_high);
    assign n_raw_t = i_sample - {8'd0, i_sample[15:8]};
    assign n_dneg  = 17'd0 - r2_d;
    assign n_sneg  = 17'd0 - r2_span;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s    <= i_sample;
            r1_neg  <= n_neg;
            r1_pos  <= (i_sample >= i_cal.pos_low);
            r1_lo   <= n_neg ? i_cal.neg_low  : i_cal.pos_low;
            r1_hi   <= n_neg ? i_cal.neg_high : i_cal.pos_high;

            r2_d    <= {1'b0, r1_s} - {1'b0, r1_lo};
            r2_span <= {1'b0, r1_hi} - {1'b0, r1_lo};
            r2_neg  <= r1_neg;
            r2_dead <= !r1_neg && !r1_pos;

            r3_dmag     <= r2_d[16] ? n_dneg[15:0] : r2_d[15:0];
            r3_smag     <= r2_span[16] ? n_sneg[15:0] : r2_span[15:0];
            r3_ctl.zero <= r2_dead || (r2_span == 17'd0) || (r2_d[16] ^ r2_span[16]);
            r3_ctl.neg  <= r2_neg && (r2_span != 17'd0);

            r_raw[0] <= n_raw_t[15:8];
            for (int i = 1; i < LAT; i++) begin
                r_raw[i] <= r_raw[i-1];
            end
        end
    end

    jacm_div #(
        .FS     (WIDE_FS),
        .STAGES (STAGES),
        .OW     (jacm_pkg::WIDE_W)
    ) u_div_wide (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_dmag (r3_dmag),
        .i_smag (r3_smag),
        .i_ctl  (r3_ctl),
        .o_res  (o_res.wide)
    );

    jacm_div #(
        .FS     (NARROW_FS),
        .STAGES (STAGES),
        .OW     (jacm_pkg::NARROW_W)
    ) u_div_narrow (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_dmag (r3_dmag),
        .i_smag (r3_smag),
        .i_ctl  (r3_ctl),
        .o_res  (o_res.narrow)
    );

    assign o_res.raw = r_raw[LAT-1];

endmodule

`default_nettype wire

// ===== hdl/jacm_merge.sv =====
// Output stage: packs both lane results and holds them in an output register plus skid.
`default_nettype none

`include "assert_macros.svh"

module jacm_merge (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_pipe_valid,
    input  wire jacm_pkg::t_lane_res                 i_x,
    input  wire jacm_pkg::t_lane_res                 i_y,
    output logic                                     o_en,
    output logic                                     o_m_valid,
    input  wire logic                                i_m_ready,
    output logic [jacm_pkg::OUT_TDATA_W-1:0]         o_m_data
);

    localparam int PAD_W = jacm_pkg::OUT_TDATA_W - 2 * jacm_pkg::RAW_W
                           - 2 * jacm_pkg::WIDE_W - 2 * jacm_pkg::NARROW_W;

    logic                                r_out_valid;
    logic                                r_skid_valid;
    logic [jacm_pkg::OUT_TDATA_W-1:0]    r_out_data;
    logic [jacm_pkg::OUT_TDATA_W-1:0]    r_skid_data;
    logic [jacm_pkg::OUT_TDATA_W-1:0]    n_data;
    logic                                n_take;
    logic                                n_push;

    assign n_data = {{PAD_W{1'b0}}, i_y.narrow, i_x.narrow, i_y.wide, i_x.wide,
                     i_y.raw, i_x.raw};
    assign n_take = r_out_valid && i_m_ready;
    assign o_en   = !r_skid_valid;
    assign n_push = i_pipe_valid && o_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (n_take) begin
                r_out_data   <= r_skid_data;
                r_skid_valid <= 1'b0;
            end
        end else if (n_push) begin
            if (!r_out_valid || n_take) begin
                r_out_data  <= n_data;
                r_out_valid <= 1'b1;
            end else begin
                r_skid_data  <= n_data;
                r_skid_valid <= 1'b1;
            end
        end else if (n_take) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out_data;

    `ASSERT_CLK(a_skid_implies_out, i_clk, i_rst_n, r_skid_valid |-> r_out_valid, "skid holds a transaction while output register is empty")
    `ASSERT_NEXT(a_skid_catches, i_clk, i_rst_n, n_push && r_out_valid && !i_m_ready, r_skid_valid, "stalled transaction not caught by skid")
    `ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_skid_valid && n_take, r_out_valid && !r_skid_valid, "skid did not drain into output register")

endmodule

`default_nettype wire

// ===== hdl/joystick_axis_calibrated_map_core.sv =====
// Top level of the two-axis joystick calibrated map.
//
// Usage:
//  - s_axis carries one X/Y sample pair per transaction; m_axis returns one
//    result per pair with raw bytes, wide and narrow calibrated positions.
//  - The cfg channel writes the eight calibration registers (index 0..7);
//    other indexes are dropped. Write only while no transaction is in flight.
//  - Throughput: one pair per clock while s_axis_tready is high. Each pair
//    passes the lane registers, the per-lane restoring dividers and the
//    output register; the divider depth follows the quotient width of
//    WIDE_FULL_SCALE (or NARROW_FULL_SCALE if larger), one quotient bit
//    per pipeline stage.
//  - Reset clears all valids and loads the default calibration.
//  - When m_axis_tready is low, the output register and a one-entry skid
//    absorb results; s_axis_tready drops only once the skid is full and the
//    pipeline then holds in place.
`default_nettype none

module joystick_axis_calibrated_map_core #(
    parameter int WIDE_FULL_SCALE   = 4095,
    parameter int NARROW_FULL_SCALE = 127
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [15:0] x_sample, [31:16] y_sample
    input  wire logic [jacm_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [7:0] x_raw_byte, [15:8] y_raw_byte, [28:16] x_wide, [41:29] y_wide,
    // [49:42] x_narrow, [57:50] y_narrow, [63:58] zero
    output logic [jacm_pkg::OUT_TDATA_W-1:0]         m_axis_tdata,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [jacm_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [jacm_pkg::SAMPLE_W-1:0]       i_cfg_data
);

    localparam int LAT = jacm_pkg::lane_latency(WIDE_FULL_SCALE, NARROW_FULL_SCALE);

    jacm_pkg::t_axis_cal  r_cal_x;
    jacm_pkg::t_axis_cal  r_cal_y;
    logic [LAT-1:0]       r_vld;
    logic                 w_en;
    jacm_pkg::t_lane_res  w_res_x;
    jacm_pkg::t_lane_res  w_res_y;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_x.neg_low  <= jacm_pkg::NEG_LOW_RST;
            r_cal_x.neg_high <= jacm_pkg::NEG_HIGH_RST;
            r_cal_x.pos_low  <= jacm_pkg::POS_LOW_RST;
            r_cal_x.pos_high <= jacm_pkg::POS_HIGH_RST;
            r_cal_y.neg_low  <= jacm_pkg::NEG_LOW_RST;
            r_cal_y.neg_high <= jacm_pkg::NEG_HIGH_RST;
            r_cal_y.pos_low  <= jacm_pkg::POS_LOW_RST;
            r_cal_y.pos_high <= jacm_pkg::POS_HIGH_RST;
        end else if (i_cfg_valid) begin
            case (jacm_pkg::t_cal_reg'(i_cfg_index))
                jacm_pkg::REG_X_NEG_LOW:  r_cal_x.neg_low  <= i_cfg_data;
                jacm_pkg::REG_X_NEG_HIGH: r_cal_x.neg_high <= i_cfg_data;
                jacm_pkg::REG_X_POS_LOW:  r_cal_x.pos_low  <= i_cfg_data;
                jacm_pkg::REG_X_POS_HIGH: r_cal_x.pos_high <= i_cfg_data;
                jacm_pkg::REG_Y_NEG_LOW:  r_cal_y.neg_low  <= i_cfg_data;
                jacm_pkg::REG_Y_NEG_HIGH: r_cal_y.neg_high <= i_cfg_data;
                jacm_pkg::REG_Y_POS_LOW:  r_cal_y.pos_low  <= i_cfg_data;
                jacm_pkg::REG_Y_POS_HIGH: r_cal_y.pos_high <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
        end
    end

    jacm_lane #(
        .WIDE_FS   (WIDE_FULL_SCALE),
        .NARROW_FS (NARROW_FULL_SCALE)
    ) u_lane_x (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sample (s_axis_tdata[15:0]),
        .i_cal    (r_cal_x),
        .o_res    (w_res_x)
    );

    jacm_lane #(
        .WIDE_FS   (WIDE_FULL_SCALE),
        .NARROW_FS (NARROW_FULL_SCALE)
    ) u_lane_y (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_sample (s_axis_tdata[31:16]),
        .i_cal    (r_cal_y),
        .o_res    (w_res_y)
    );

    jacm_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pipe_valid (r_vld[LAT-1]),
        .i_x          (w_res_x),
        .i_y          (w_res_y),
        .o_en         (w_en),
        .o_m_valid    (m_axis_tvalid),
        .i_m_ready    (m_axis_tready),
        .o_m_data     (m_axis_tdata)
    );

endmodule

`default_nettype wire
